@@ rtl/fqsr_pkg.sv @@
`timescale 1ns / 1ps

package fqsr_pkg;

  // Queue geometry.
  localparam int DEPTH    = 16;
  localparam int ID_WIDTH = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Port field widths.
  localparam int KIND_W   = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } fqsr_cmd_t;

endpackage

@@ rtl/fqsr_ctrl.sv @@
`timescale 1ns / 1ps

module fqsr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output fqsr_pkg::fqsr_cmd_t cmd
);
  import fqsr_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  // A new beat waits while an operation runs or a result is held back.
  assign in_stall    = (state_r == ST_EXEC) || (out_valid_r && out_stall);
  assign accept      = in_valid && !in_stall;
  assign cmd.capture = accept;
  assign cmd.execute = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_EXEC;
          end
          if (out_valid_r && !out_stall) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_EXEC: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ rtl/fqsr_dp.sv @@
`timescale 1ns / 1ps

module fqsr_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fqsr_pkg::fqsr_cmd_t           cmd,
  input  logic [fqsr_pkg::KIND_W-1:0]   in_kind,
  input  logic [fqsr_pkg::ID_W-1:0]     in_id,
  output logic [fqsr_pkg::STATUS_W-1:0] out_status,
  output logic [fqsr_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_found,
  output logic [fqsr_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_empty_res
);
  import fqsr_pkg::*;

  op_t                 kind_r;
  logic [ID_WIDTH-1:0] key_r;
  logic [ID_WIDTH-1:0] cells_r   [DEPTH];
  logic [ID_WIDTH-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0]    occ_r;
  logic [CNT_W-1:0]    occ_nxt;
  status_t             status_r;
  status_t             status_nxt;
  logic [VALUE_W-1:0]  value_r;
  logic [VALUE_W-1:0]  value_nxt;
  logic                found_r;
  logic                found_nxt;

  logic [DEPTH-1:0]    match;
  logic [DEPTH-1:0]    first;
  logic [DEPTH-1:0]    shift_en;
  logic [DEPTH-1:0]    wr_en;
  logic                hit;
  logic                is_full;
  logic                is_empty;
  logic                push_ok;

  assign is_full  = (occ_r == CNT_W'(DEPTH));
  assign is_empty = (occ_r == '0);

  // Every live cell compares against the key at once; the oldest match wins.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cmp
    assign match[g] = (CNT_W'(g) < occ_r) && (cells_r[g] == key_r);
    assign wr_en[g] = push_ok && (occ_r == CNT_W'(g));
  end

  assign hit   = |match;
  assign first = match & (~match + DEPTH'(1));

  always_comb begin
    status_nxt = STS_OK;
    value_nxt  = '0;
    found_nxt  = 1'b0;
    occ_nxt    = occ_r;
    shift_en   = '0;
    push_ok    = 1'b0;
    case (kind_r)
      OP_PUSH: begin
        if (is_full) begin
          status_nxt = STS_FULL;
        end else begin
          push_ok = 1'b1;
          occ_nxt = occ_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (is_empty) begin
          status_nxt = STS_MISS;
        end else begin
          value_nxt = VALUE_W'(cells_r[0]);
          shift_en  = '1;
          occ_nxt   = occ_r - CNT_W'(1);
        end
      end
      OP_FIND: begin
        found_nxt  = hit;
        status_nxt = hit ? STS_OK : STS_MISS;
      end
      OP_REMOVE: begin
        if (hit) begin
          found_nxt = 1'b1;
          shift_en  = ~(first - DEPTH'(1));
          occ_nxt   = occ_r - CNT_W'(1);
        end else begin
          status_nxt = STS_MISS;
        end
      end
      default: begin
        status_nxt = STS_MISS;
      end
    endcase
  end

  // Cells at and behind the removed position take their neighbor's value.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g < DEPTH - 1) begin : g_mid
      assign cells_nxt[g] = wr_en[g]    ? key_r :
                            shift_en[g] ? cells_r[g+1] : cells_r[g];
    end else begin : g_last
      assign cells_nxt[g] = wr_en[g] ? key_r : cells_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= op_t'(in_kind);
      key_r  <= ID_WIDTH'(in_id);
    end
    if (cmd.execute) begin
      cells_r  <= cells_nxt;
      status_r <= status_nxt;
      value_r  <= value_nxt;
      found_r  <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (cmd.execute) begin
      occ_r <= occ_nxt;
    end
  end

  assign out_status    = status_r;
  assign out_value     = value_r;
  assign out_found     = found_r;
  assign out_count     = COUNT_W'(occ_r);
  assign out_empty_res = is_empty;

endmodule

@@ rtl/fifo_queue_with_search_and_remove.sv @@
`timescale 1ns / 1ps
// The controller captures an accepted beat, then runs the parallel
// compare-and-shift over all cells and registers the result. No new beat
// is taken while one executes or while a stalled result is held.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; cell contents are left as they are and never read until written.
module fifo_queue_with_search_and_remove (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fqsr_pkg::KIND_W-1:0]   in_kind,
  input  logic [fqsr_pkg::ID_W-1:0]     in_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fqsr_pkg::STATUS_W-1:0] out_status,
  output logic [fqsr_pkg::VALUE_W-1:0]  out_value,
  output logic                          out_found,
  output logic [fqsr_pkg::COUNT_W-1:0]  out_count,
  output logic                          out_empty_res
);
  import fqsr_pkg::*;

  // The controller sequences each beat: capture it, then execute it against
  // the cell array while loading the result register.
  fqsr_cmd_t cmd;

  fqsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // The datapath holds the cells, the occupancy count and the result
  // register. Count and empty flag follow the occupancy, which cannot move
  // while a result is still waiting to be taken.
  fqsr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_kind       (in_kind),
    .in_id         (in_id),
    .out_status    (out_status),
    .out_value     (out_value),
    .out_found     (out_found),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

endmodule

@@ rtl/fqsr_chk.sv @@
`timescale 1ns / 1ps

module fqsr_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [fqsr_pkg::KIND_W-1:0]   in_kind,
  input logic [fqsr_pkg::ID_W-1:0]     in_id,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [fqsr_pkg::STATUS_W-1:0] out_status,
  input logic [fqsr_pkg::VALUE_W-1:0]  out_value,
  input logic                          out_found,
  input logic [fqsr_pkg::COUNT_W-1:0]  out_count,
  input logic                          out_empty_res
);
  import fqsr_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_kind, in_id, out_value};

  // An accepted beat holds out_valid low while it executes, then raises out_valid with its result.
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid ##1 out_valid)
    else $error("result did not follow accepted beat");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)))
    else $error("empty flag disagrees with count");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_FULL) |-> (out_count == COUNT_W'(DEPTH)) && !out_found)
    else $error("full status with queue not full");

endmodule

bind fifo_queue_with_search_and_remove fqsr_chk u_chk (.*);
